// ----- rtl/tsag_pkg.sv -----
`timescale 1ns / 1ps
package tsag_pkg;

    // default sizes of the unit
    localparam int MAX_DIM_DEF     = 4096;
    localparam int TEXEL_BYTES_DEF = 4;

    // fixed field widths
    localparam int COORD_W   = 24;
    localparam int FRAC_W    = 16;
    localparam int ADDR_W    = 32;
    localparam int WEIGHT_W  = 17;
    localparam int CFG_DIM_W = 13;
    localparam int MODE_W    = 2;
    localparam int IDX_W     = 3;
    localparam int CORNER_W  = 2;

    // address mode codes
    typedef enum logic [MODE_W-1:0] {
        MODE_CLAMP  = 2'd0,
        MODE_WRAP   = 2'd1,
        MODE_MIRROR = 2'd2
    } addr_mode_t;

    // register indices of the configuration port
    typedef enum logic [IDX_W-1:0] {
        REG_BASE_ADDRESS = 3'd0,
        REG_TEX_WIDTH    = 3'd1,
        REG_TEX_HEIGHT   = 3'd2,
        REG_MODE_U       = 3'd3,
        REG_MODE_V       = 3'd4,
        REG_FILTER_MODE  = 3'd5
    } reg_index_t;

    // configuration register set
    typedef struct packed {
        logic [ADDR_W-1:0]    base_address;
        logic [CFG_DIM_W-1:0] tex_width;
        logic [CFG_DIM_W-1:0] tex_height;
        logic [MODE_W-1:0]    mode_u;
        logic [MODE_W-1:0]    mode_v;
        logic                 filter_mode;
    } cfg_t;

endpackage

// ----- rtl/tsag_if.sv -----
`timescale 1ns / 1ps
// coordinate channel
interface tsag_coord_if import tsag_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  coord_u;
    logic signed [COORD_W-1:0]  coord_v;

    modport source (output valid, output coord_u, output coord_v, input ready);
    modport sink   (input valid, input coord_u, input coord_v, output ready);
endinterface

// result channel
interface tsag_result_if import tsag_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ADDR_W-1:0]    texel_address;
    logic [WEIGHT_W-1:0]  weight;
    logic [CORNER_W-1:0]  corner;
    logic                 last;

    modport source (output valid, output texel_address, output weight, output corner,
                    output last, input ready);
    modport sink   (input valid, input texel_address, input weight, input corner,
                    input last, output ready);
endinterface

// configuration write channel
interface tsag_cfg_if import tsag_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   index;
    logic [ADDR_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/texture_sample_address_gen_core.sv -----
`timescale 1ns / 1ps
// path to the first address: product register, floor stage and the bit-per-stage
//   remainder pipeline of the front end, the queue, product stage and output register
// throughput: point mode one coordinate per cycle unless the queue or result channel
//   stalls; bilinear mode one coordinate per four addresses on the single channel
// reset: asynchronous, clears all valid flags and loads the register defaults
module texture_sample_address_gen_core import tsag_pkg::*; #(
    parameter int MAX_DIM     = MAX_DIM_DEF,
    parameter int TEXEL_BYTES = TEXEL_BYTES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    tsag_coord_if.sink    coord,
    tsag_result_if.source result,
    tsag_cfg_if.sink      cfg
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int QW    = 4 * DIM_W + 2 * FRAC_W;

    cfg_t              cfg_reg;
    logic [DIM_W-1:0]  eff_w, eff_h;
    logic              q_push, q_full, q_pop, q_valid;
    logic [QW-1:0]     q_wdata, q_rdata;

    // effective texture size
    function automatic logic [DIM_W-1:0] eff_size(logic [CFG_DIM_W-1:0] s);
        begin
            if (s == '0)
            begin
                return DIM_W'(1);
            end
            else if (32'(s) > 32'(MAX_DIM))
            begin
                return DIM_W'(MAX_DIM);
            end
            return DIM_W'(s);
        end
    endfunction

    assign eff_w     = eff_size(cfg_reg.tex_width);
    assign eff_h     = eff_size(cfg_reg.tex_height);
    assign cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_address <= '0;
            cfg_reg.tex_width    <= CFG_DIM_W'(1);
            cfg_reg.tex_height   <= CFG_DIM_W'(1);
            cfg_reg.mode_u       <= MODE_CLAMP;
            cfg_reg.mode_v       <= MODE_CLAMP;
            cfg_reg.filter_mode  <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (reg_index_t'(cfg.index))
                REG_BASE_ADDRESS: cfg_reg.base_address <= cfg.data;
                REG_TEX_WIDTH:    cfg_reg.tex_width    <= cfg.data[CFG_DIM_W-1:0];
                REG_TEX_HEIGHT:   cfg_reg.tex_height   <= cfg.data[CFG_DIM_W-1:0];
                REG_MODE_U:       cfg_reg.mode_u       <= cfg.data[MODE_W-1:0];
                REG_MODE_V:       cfg_reg.mode_v       <= cfg.data[MODE_W-1:0];
                REG_FILTER_MODE:  cfg_reg.filter_mode  <= cfg.data[0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    tsag_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .eff_w  (eff_w),
        .eff_h  (eff_h),
        .coord  (coord),
        .q_push (q_push),
        .q_data (q_wdata),
        .q_full (q_full)
    );

    tsag_queue #(
        .W     (QW),
        .DEPTH (4)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .valid (q_valid)
    );

    tsag_back #(
        .MAX_DIM     (MAX_DIM),
        .TEXEL_BYTES (TEXEL_BYTES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .eff_w   (eff_w),
        .q_valid (q_valid),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

// ----- rtl/tsag_queue.sv -----
`timescale 1ns / 1ps
module tsag_queue import tsag_pkg::*; #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign valid = (cnt_reg != '0);
    assign rdata = mem_reg[rd_ptr_reg];

endmodule

// ----- rtl/tsag_front.sv -----
`timescale 1ns / 1ps
module tsag_front import tsag_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF,
    localparam int DIM_W  = $clog2(MAX_DIM + 1),
    localparam int QW     = 4 * DIM_W + 2 * FRAC_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic [DIM_W-1:0]  eff_w,
    input  logic [DIM_W-1:0]  eff_h,
    tsag_coord_if.sink        coord,
    output logic              q_push,
    output logic [QW-1:0]     q_data,
    input  logic              q_full
);

    localparam int PROD_W = COORD_W + DIM_W + 1;
    localparam int INT_W  = PROD_W + 1 - FRAC_W;
    localparam int MW     = DIM_W + 1;
    localparam int NSTG   = INT_W + 1;

    typedef struct packed {
        logic signed [INT_W-1:0] c;
        logic [INT_W-1:0]        a;
        logic [MW-1:0]           rem;
        logic [MW-1:0]           m;
        logic [MODE_W-1:0]       mode;
    } ax_t;

    typedef struct packed {
        ax_t               u;
        ax_t               v;
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fy;
    } fs_t;

    typedef struct packed {
        logic [DIM_W-1:0]  x0;
        logic [DIM_W-1:0]  x1;
        logic [DIM_W-1:0]  y0;
        logic [DIM_W-1:0]  y1;
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fy;
    } qe_t;

    logic                      en;
    logic                      m_vld_reg;
    logic signed [PROD_W-1:0]  du_reg, dv_reg;
    logic signed [PROD_W-1:0]  du_next, dv_next;
    logic [NSTG-1:0]           vld_reg;
    fs_t                       pipe_reg  [NSTG];
    fs_t                       pipe_next [NSTG];
    logic [FRAC_W-1:0]         fu, fv;
    qe_t                       qe;
    logic [2*DIM_W-1:0]        mu, mv;

    // floor, fraction, magnitude and modulus of one axis
    function automatic ax_t mk_axis(logic signed [PROD_W-1:0] d, logic half,
                                    logic [DIM_W-1:0] size, logic [MODE_W-1:0] mode,
                                    output logic [FRAC_W-1:0] frac);
        logic signed [PROD_W:0] s;
        ax_t                    x;
        begin
            s      = {d[PROD_W-1], d} - (PROD_W+1)'(half ? (1 << (FRAC_W - 1)) : 0);
            x.c    = s[PROD_W:FRAC_W];
            x.a    = x.c[INT_W-1] ? INT_W'(-x.c) : INT_W'(x.c);
            x.rem  = '0;
            x.m    = (mode == MODE_MIRROR) ? {size, 1'b0} : {1'b0, size};
            x.mode = mode;
            frac   = half ? s[FRAC_W-1:0] : '0;
            return x;
        end
    endfunction

    // one restoring remainder step, most significant bit first
    function automatic ax_t div_step(ax_t x, int k);
        logic [MW:0] t;
        ax_t         y;
        begin
            y = x;
            t = {x.rem, x.a[INT_W-1-k]};
            if (t >= {1'b0, x.m})
            begin
                t = t - {1'b0, x.m};
            end
            y.rem = t[MW-1:0];
            return y;
        end
    endfunction

    // apply the address mode to the cell and its right or lower neighbour
    function automatic logic [2*DIM_W-1:0] map_axis(ax_t x, logic [DIM_W-1:0] size);
        logic [MW-1:0]          r, r1;
        logic [MW:0]            sum;
        logic signed [INT_W:0]  c0, c1, lim;
        logic [DIM_W-1:0]       lo, hi;
        begin
            r   = (x.c[INT_W-1] && x.rem != '0) ? x.m - x.rem : x.rem;
            sum = {1'b0, r} + 1'b1;
            r1  = (sum == {1'b0, x.m}) ? '0 : sum[MW-1:0];
            c0  = {x.c[INT_W-1], x.c};
            c1  = c0 + 1'b1;
            lim = $signed({{(INT_W + 1 - DIM_W){1'b0}}, size}) - 1'b1;
            case (x.mode)
                MODE_WRAP:
                begin
                    lo = DIM_W'(r);
                    hi = DIM_W'(r1);
                end
                MODE_MIRROR:
                begin
                    lo = (r  < {1'b0, size}) ? DIM_W'(r)  : DIM_W'(x.m - 1'b1 - r);
                    hi = (r1 < {1'b0, size}) ? DIM_W'(r1) : DIM_W'(x.m - 1'b1 - r1);
                end
                default:
                begin
                    lo = (c0 < 0) ? '0 : ((c0 > lim) ? DIM_W'(lim) : DIM_W'(c0));
                    hi = (c1 < 0) ? '0 : ((c1 > lim) ? DIM_W'(lim) : DIM_W'(c1));
                end
            endcase
            return {lo, hi};
        end
    endfunction

    // whole pipeline moves unless the last stage is blocked by the queue
    assign en          = !vld_reg[NSTG-1] || !q_full;
    assign coord.ready = en;
    assign q_push      = vld_reg[NSTG-1] && !q_full;

    // scaling by the texture size
    assign du_next = coord.coord_u * $signed({1'b0, eff_w});
    assign dv_next = coord.coord_v * $signed({1'b0, eff_h});

    // floor stage and remainder steps
    always_comb
    begin
        pipe_next[0].u  = mk_axis(du_reg, cfg.filter_mode, eff_w, cfg.mode_u, fu);
        pipe_next[0].v  = mk_axis(dv_reg, cfg.filter_mode, eff_h, cfg.mode_v, fv);
        pipe_next[0].fx = fu;
        pipe_next[0].fy = fv;
        for (int i = 1; i < NSTG; i++)
        begin
            pipe_next[i]   = pipe_reg[i-1];
            pipe_next[i].u = div_step(pipe_reg[i-1].u, i - 1);
            pipe_next[i].v = div_step(pipe_reg[i-1].v, i - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
            vld_reg   <= '0;
        end
        else if (en)
        begin
            m_vld_reg <= coord.valid;
            vld_reg   <= {vld_reg[NSTG-2:0], m_vld_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            du_reg <= du_next;
            dv_reg <= dv_next;
            for (int i = 0; i < NSTG; i++)
            begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
    end

    // queue entry from the last remainder step
    always_comb
    begin
        mu     = map_axis(pipe_reg[NSTG-1].u, eff_w);
        mv     = map_axis(pipe_reg[NSTG-1].v, eff_h);
        qe.x0  = mu[2*DIM_W-1:DIM_W];
        qe.x1  = mu[DIM_W-1:0];
        qe.y0  = mv[2*DIM_W-1:DIM_W];
        qe.y1  = mv[DIM_W-1:0];
        qe.fx  = pipe_reg[NSTG-1].fx;
        qe.fy  = pipe_reg[NSTG-1].fy;
    end

    assign q_data = qe;

endmodule

// ----- rtl/tsag_back.sv -----
`timescale 1ns / 1ps
module tsag_back import tsag_pkg::*; #(
    parameter int MAX_DIM     = MAX_DIM_DEF,
    parameter int TEXEL_BYTES = TEXEL_BYTES_DEF,
    localparam int DIM_W      = $clog2(MAX_DIM + 1),
    localparam int QW         = 4 * DIM_W + 2 * FRAC_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic [DIM_W-1:0]  eff_w,
    input  logic              q_valid,
    input  logic [QW-1:0]     q_data,
    output logic              q_pop,
    tsag_result_if.source     result
);

    localparam int WP_W = 2 * WEIGHT_W;
    localparam logic [WEIGHT_W-1:0] ONE = WEIGHT_W'(1 << FRAC_W);

    typedef struct packed {
        logic [DIM_W-1:0]  x0;
        logic [DIM_W-1:0]  x1;
        logic [DIM_W-1:0]  y0;
        logic [DIM_W-1:0]  y1;
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fy;
    } qe_t;

    qe_t                   qe;
    logic                  adv;
    logic                  last_c;
    logic [DIM_W-1:0]      xs, ys;
    logic [WEIGHT_W-1:0]   wa, wb;
    logic [CORNER_W-1:0]   cnt_reg, cnt_next;

    logic                  a_vld_reg;
    logic [2*DIM_W-1:0]    yw_reg;
    logic [DIM_W-1:0]      x_reg;
    logic [WP_W-1:0]       wp_reg;
    logic [CORNER_W-1:0]   corner_reg;
    logic                  last_reg;

    logic                  out_vld_reg;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [WEIGHT_W-1:0]   weight_reg, weight_next;
    logic [CORNER_W-1:0]   ocorner_reg;
    logic                  olast_reg;
    logic [2*DIM_W:0]      idx;

    assign qe  = q_data;
    assign adv = !out_vld_reg || result.ready;

    // corner selection for the current transaction
    always_comb
    begin
        xs       = cnt_reg[0] ? qe.x1 : qe.x0;
        ys       = cnt_reg[1] ? qe.y1 : qe.y0;
        wa       = cnt_reg[0] ? {1'b0, qe.fx} : ONE - {1'b0, qe.fx};
        wb       = cnt_reg[1] ? {1'b0, qe.fy} : ONE - {1'b0, qe.fy};
        last_c   = !cfg.filter_mode || (cnt_reg == CORNER_W'(3));
        cnt_next = last_c ? '0 : cnt_reg + 1'b1;
        q_pop    = adv && q_valid && last_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            a_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg   <= q_valid;
            out_vld_reg <= a_vld_reg;
            if (q_valid)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    // product stage: row offset and weight
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            yw_reg     <= ys * eff_w;
            x_reg      <= xs;
            wp_reg     <= wa * wb;
            corner_reg <= cnt_reg;
            last_reg   <= last_c;
        end
    end

    // address add and weight rounding
    always_comb
    begin
        idx         = {1'b0, yw_reg} + (2*DIM_W+1)'(x_reg);
        addr_next   = cfg.base_address + ADDR_W'(ADDR_W'(idx) * ADDR_W'(TEXEL_BYTES));
        weight_next = WEIGHT_W'((wp_reg + WP_W'(1 << (FRAC_W - 1))) >> FRAC_W);
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            addr_reg    <= addr_next;
            weight_reg  <= weight_next;
            ocorner_reg <= corner_reg;
            olast_reg   <= last_reg;
        end
    end

    assign result.valid         = out_vld_reg;
    assign result.texel_address = addr_reg;
    assign result.weight        = weight_reg;
    assign result.corner        = ocorner_reg;
    assign result.last          = olast_reg;

endmodule

// ----- dv/tsag_tb_if.sv -----
`timescale 1ns / 1ps
// channel interfaces come from the rtl; this file only groups testbench-side types
package tsag_tb_pkg;
    import tsag_pkg::*;

    // one expected address result
    typedef struct packed {
        logic [ADDR_W-1:0]   texel_address;
        logic [WEIGHT_W-1:0] weight;
        logic [CORNER_W-1:0] corner;
        logic                last;
    } texel_ref_t;
endpackage

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    import tsag_pkg::*;
    import tsag_tb_pkg::*;

    localparam int SETTLE_CYCLES = 80;

    logic clk;
    logic rst_n;

    tsag_coord_if  coord_ch();
    tsag_result_if result_ch();
    tsag_cfg_if    cfg_ch();

    texture_sample_address_gen_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .coord  (coord_ch.sink),
        .result (result_ch.source),
        .cfg    (cfg_ch.sink)
    );

    // shadow of the register set
    logic [31:0] sh_base;
    logic [12:0] sh_width;
    logic [12:0] sh_height;
    logic [1:0]  sh_mode_u;
    logic [1:0]  sh_mode_v;
    logic        sh_filter;

    texel_ref_t texel_queue[$];
    int         error_count;
    int         sent_count;
    int         checked_count;
    int         src_idle_pct;
    int         snk_stall_pct;

    // clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // effective texture size
    function automatic longint eff_dim(input logic [12:0] s);
        if (s == 0)
            return 1;
        if (s > 4096)
            return 4096;
        return longint'(s);
    endfunction

    function automatic longint floor16(input longint d);
        return d >>> 16;
    endfunction

    // apply clamp, wrap or mirror to one integer texel coordinate
    function automatic longint wrap_axis(input longint c, input longint n, input logic [1:0] m);
        longint r;
        if (m == MODE_WRAP)
        begin
            r = c % n;
            if (r < 0)
                r += n;
            return r;
        end
        if (m == MODE_MIRROR)
        begin
            r = c % (2 * n);
            if (r < 0)
                r += 2 * n;
            return (r < n) ? r : 2 * n - 1 - r;
        end
        if (c < 0)
            return 0;
        if (c > n - 1)
            return n - 1;
        return c;
    endfunction

    function automatic logic [31:0] byte_addr(input longint x, input longint y, input longint w);
        longint idx;
        idx = y * w + x;
        return sh_base + 32'(idx * 4);
    endfunction

    // work out the addresses a coordinate produces
    task automatic predict_texels(input logic signed [23:0] u, input logic signed [23:0] v);
        longint w, h, du, dv, cx, cy, fx, fy, wa, wb;
        texel_ref_t t;
        w  = eff_dim(sh_width);
        h  = eff_dim(sh_height);
        du = longint'(u) * w;
        dv = longint'(v) * h;
        if (!sh_filter)
        begin
            t.texel_address = byte_addr(wrap_axis(floor16(du), w, sh_mode_u),
                                        wrap_axis(floor16(dv), h, sh_mode_v), w);
            t.weight = 17'd65536;
            t.corner = 2'd0;
            t.last   = 1'b1;
            texel_queue.insert(texel_queue.size(), t);
        end
        else
        begin
            du -= 32768;
            dv -= 32768;
            cx = floor16(du);
            cy = floor16(dv);
            fx = du - cx * 65536;
            fy = dv - cy * 65536;
            for (int k = 0; k < 4; k++)
            begin
                wa = k[0] ? fx : 65536 - fx;
                wb = k[1] ? fy : 65536 - fy;
                t.texel_address = byte_addr(wrap_axis(cx + k[0], w, sh_mode_u),
                                            wrap_axis(cy + k[1], h, sh_mode_v), w);
                t.weight = 17'((wa * wb + 32768) >> 16);
                t.corner = 2'(k);
                t.last   = (k == 3);
                texel_queue.insert(texel_queue.size(), t);
            end
        end
    endtask

    // send one coordinate transaction; valid stays up for a following one
    task automatic send_coord(input logic signed [23:0] u, input logic signed [23:0] v);
        while ($urandom_range(99) < src_idle_pct)
        begin
            coord_ch.valid <= 1'b0;
            @(posedge clk);
        end
        coord_ch.valid   <= 1'b1;
        coord_ch.coord_u <= u;
        coord_ch.coord_v <= v;
        @(posedge clk);
        while (!coord_ch.ready)
            @(posedge clk);
        predict_texels(u, v);
        sent_count++;
    endtask

    // wait until all results are in, then let the pipeline empty
    task automatic drain();
        coord_ch.valid <= 1'b0;
        while (texel_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, only while idle
    task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_BASE_ADDRESS: sh_base   = val;
            REG_TEX_WIDTH:    sh_width  = val[12:0];
            REG_TEX_HEIGHT:   sh_height = val[12:0];
            REG_MODE_U:       sh_mode_u = val[1:0];
            REG_MODE_V:       sh_mode_v = val[1:0];
            REG_FILTER_MODE:  sh_filter = val[0];
            default: ;
        endcase
    endtask

    task automatic setup(input logic [31:0] base, input logic [12:0] w, input logic [12:0] h,
                         input logic [1:0] mu, input logic [1:0] mv, input logic filt);
        drain();
        write_reg(REG_BASE_ADDRESS, base);
        write_reg(REG_TEX_WIDTH, 32'(w));
        write_reg(REG_TEX_HEIGHT, 32'(h));
        write_reg(REG_MODE_U, 32'(mu));
        write_reg(REG_MODE_V, 32'(mv));
        write_reg(REG_FILTER_MODE, 32'(filt));
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic signed [23:0] rand_coord();
        case ($urandom_range(4))
            0: return 24'($urandom);
            1: return 24'sd65536 + 24'($urandom_range(65535)) - 24'sd32768;
            2: return 24'($urandom_range(131072));
            3: return -24'sd1 * 24'($urandom_range(262144));
            default: return 24'($urandom_range(65536));
        endcase
    endfunction

    function automatic logic [12:0] rand_dim();
        case ($urandom_range(5))
            0: return 13'($urandom_range(1, 4));
            1: return 13'($urandom);
            default: return 13'($urandom_range(1, 64));
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin
        texel_ref_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (texel_queue.size() == 0)
            begin
                $display("%0t: unexpected result addr %h weight %0d corner %0d last %0d",
                         $time, result_ch.texel_address, result_ch.weight,
                         result_ch.corner, result_ch.last);
                error_count++;
            end
            else
            begin
                want = texel_queue.pop_front();
                checked_count++;
                if (result_ch.texel_address !== want.texel_address)
                begin
                    $display("%0t: texel_address expected %h actual %h", $time,
                             want.texel_address, result_ch.texel_address);
                    error_count++;
                end
                if (result_ch.weight !== want.weight)
                begin
                    $display("%0t: weight expected %0d actual %0d", $time,
                             want.weight, result_ch.weight);
                    error_count++;
                end
                if (result_ch.corner !== want.corner)
                begin
                    $display("%0t: corner expected %0d actual %0d", $time,
                             want.corner, result_ch.corner);
                    error_count++;
                end
                if (result_ch.last !== want.last)
                begin
                    $display("%0t: last expected %0d actual %0d", $time,
                             want.last, result_ch.last);
                    error_count++;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // directed: field extremes and special cases
    task automatic test_directed();
        logic signed [23:0] edges[8];
        edges = '{24'sh800000, 24'sh7fffff, 24'sd0, -24'sd1, 24'sd65536, 24'sd32768,
                  24'sd65535, 24'sh7f0000};
        setup(32'hffff_fff0, 13'd0, 13'd8191, MODE_CLAMP, 2'd3, 1'b0);
        for (int i = 0; i < 8; i++)
            send_coord(edges[i], edges[7 - i]);
        setup(32'h0000_1000, 13'd5, 13'd3, MODE_WRAP, MODE_MIRROR, 1'b1);
        for (int i = 0; i < 8; i++)
            send_coord(edges[i], edges[(i + 3) % 8]);
        setup(32'h1234_5678, 13'd4096, 13'd4097, MODE_MIRROR, MODE_WRAP, 1'b1);
        for (int i = 0; i < 8; i++)
            send_coord(edges[(i + 5) % 8], edges[i]);
    endtask

    // random content over a spread of register settings
    task automatic test_random(input int items, input int idle, input int stall);
        src_idle_pct  = idle;
        snk_stall_pct = stall;
        for (int i = 0; i < items; i++)
        begin
            if (i % 23 == 0)
                setup($urandom, rand_dim(), rand_dim(), 2'($urandom), 2'($urandom),
                      1'($urandom));
            send_coord(rand_coord(), rand_coord());
        end
    endtask

    // sender holds off until everything has come back
    task automatic test_pause();
        setup(32'h0, 13'd16, 13'd16, MODE_MIRROR, MODE_MIRROR, 1'b1);
        send_coord(24'sd12345, -24'sd54321);
        coord_ch.valid <= 1'b0;
        while (texel_queue.size() != 0)
            @(posedge clk);
        send_coord(-24'sd99999, 24'sd77777);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        coord_ch.valid  = 1'b0;
        coord_ch.coord_u = '0;
        coord_ch.coord_v = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_BASE_ADDRESS;
        cfg_ch.data     = '0;
        sh_base = 0; sh_width = 1; sh_height = 1;
        sh_mode_u = MODE_CLAMP; sh_mode_v = MODE_CLAMP; sh_filter = 1'b0;
        error_count = 0; sent_count = 0; checked_count = 0;
        src_idle_pct = 0; snk_stall_pct = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(110, 0, 0);
        test_random(110, 83, 0);
        test_random(110, 0, 83);
        test_random(100, 24, 24);
        test_pause();
        src_idle_pct = 0; snk_stall_pct = 0;
        drain();
        $display("coordinates sent: %0d, address results checked: %0d", sent_count,
                 checked_count);
        $display("covered point and bilinear filtering, clamp/wrap/mirror and size limits");
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // overall timeout
    initial
    begin
        #4000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

// ----- texture_sample_address_gen_core.f -----
rtl/tsag_pkg.sv
rtl/tsag_if.sv
rtl/tsag_queue.sv
rtl/tsag_front.sv
rtl/tsag_back.sv
rtl/texture_sample_address_gen_core.sv
dv/tsag_tb_if.sv
dv/testbench.sv
